@@ design/aes_block_cipher_defines.svh @@
// ----------------------------------------------------------------------------
// aes block cipher assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef AES_BLOCK_CIPHER_DEFINES_SVH
`define AES_BLOCK_CIPHER_DEFINES_SVH

// condition holds every cycle out of reset
`define AES_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define AES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/aes_pkg.sv @@
// ----------------------------------------------------------------------------
// aes package
// payload types, control structs, tables and byte-level functions
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

    typedef struct packed {
        logic        func;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
    } aes_in_t;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } aes_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } aes_state_t;

    localparam logic [2:0] CFG_KEY_SIZE   = 3'd0;
    localparam logic [2:0] CFG_KEY_WORD_0 = 3'd1;
    localparam logic [2:0] CFG_KEY_WORD_1 = 3'd2;
    localparam logic [2:0] CFG_KEY_WORD_2 = 3'd3;
    localparam logic [2:0] CFG_KEY_WORD_3 = 3'd4;

    localparam logic [1:0] KEY_SIZE_128 = 2'd0;
    localparam logic [1:0] KEY_SIZE_192 = 2'd1;

    localparam int ROW_DEPTH = 16;

    typedef struct packed {
        logic         en;
        logic [3:0]   enc_row;
        logic [3:0]   dec_row;
        logic [127:0] enc_data;
        logic [127:0] dec_data;
    } aes_rk_wr_t;

    typedef struct packed {
        logic load;
        logic step;
        logic decrypt;
        logic last;
    } aes_rnd_ctl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
        8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
        8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
        8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
        8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
        8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
        8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
        8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
        8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
        8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
        8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
        8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
        8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
        8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
        8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
        8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
        8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
        8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
        8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
        8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
        8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
        8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
    };

    function automatic logic [3:0] rounds_of(input logic [1:0] ks);
        logic [3:0] nr;
        case (ks)
            KEY_SIZE_128: nr = 4'd10;
            KEY_SIZE_192: nr = 4'd12;
            default:      nr = 4'd14;
        endcase
        return nr;
    endfunction

    function automatic logic [3:0] nk_of(input logic [1:0] ks);
        logic [3:0] nk;
        case (ks)
            KEY_SIZE_128: nk = 4'd4;
            KEY_SIZE_192: nk = 4'd6;
            default:      nk = 4'd8;
        endcase
        return nk;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] w);
        logic [7:0] a0, a1, a2, a3;
        a0 = w[31:24];
        a1 = w[23:16];
        a2 = w[15:8];
        a3 = w[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
        logic [7:0] a [4];
        logic [7:0] m2 [4];
        logic [7:0] m4 [4];
        logic [7:0] m8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int k = 0; k < 4; k++) begin
            a[k]  = w[31-8*k -: 8];
            m2[k] = xtime(a[k]);
            m4[k] = xtime(m2[k]);
            m8[k] = xtime(m4[k]);
            m9[k] = m8[k] ^ a[k];
            mb[k] = m8[k] ^ m2[k] ^ a[k];
            md[k] = m8[k] ^ m4[k] ^ a[k];
            me[k] = m8[k] ^ m4[k] ^ m2[k];
        end
        return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

endpackage

`default_nettype wire

@@ design/aes_key_exp.sv @@
// ----------------------------------------------------------------------------
// aes key expansion
// one schedule word per cycle, rows of four words written to the key store
// ----------------------------------------------------------------------------
`default_nettype none

module aes_key_exp (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire  [1:0]          key_size,
    input  wire  [255:0]        key,
    output aes_pkg::aes_rk_wr_t wr,
    output logic                done
);
    import aes_pkg::*;

    logic [31:0]  kw [8];
    logic [31:0]  win_reg [8];
    logic [31:0]  buf_reg [3];
    logic [127:0] row_reg;
    logic [3:0]   row_idx_reg;
    logic         row_vld_reg;
    logic         done_reg;
    logic         busy_reg;
    logic [5:0]   cnt_reg;
    logic [2:0]   j_reg;
    logic [7:0]   rcon_reg;
    logic [3:0]   nr;
    logic [3:0]   nk;
    logic [31:0]  prev;
    logic [31:0]  far;
    logic [31:0]  t;
    logic [31:0]  word;
    logic         from_key;
    logic         is_last;
    logic         inner;

    for (genvar k = 0; k < 8; k++) begin : g_kw
        assign kw[k] = key[255-32*k -: 32];
    end

    assign nr       = rounds_of(key_size);
    assign nk       = nk_of(key_size);
    assign from_key = (cnt_reg < 6'(nk));
    assign is_last  = (cnt_reg == {nr, 2'b11});
    assign prev     = win_reg[7];

    always_comb
    begin
        case (key_size)
            KEY_SIZE_128: far = win_reg[4];
            KEY_SIZE_192: far = win_reg[2];
            default:      far = win_reg[0];
        endcase
        if (j_reg == 3'd0)
            t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_reg, 24'd0};
        else if (nk == 4'd8 && j_reg == 3'd4)
            t = sub_word(prev);
        else
            t = prev;
        word = from_key ? kw[cnt_reg[2:0]] : (far ^ t);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            row_vld_reg <= 1'b0;
            cnt_reg     <= 6'd0;
            j_reg       <= 3'd0;
            rcon_reg    <= 8'h01;
        end
        else if (start)
        begin
            busy_reg    <= 1'b1;
            done_reg    <= 1'b0;
            row_vld_reg <= 1'b0;
            cnt_reg     <= 6'd0;
            j_reg       <= 3'd0;
            rcon_reg    <= 8'h01;
        end
        else
        begin
            // done follows the write of the last row
            done_reg    <= row_vld_reg && (row_idx_reg == nr);
            row_vld_reg <= busy_reg && (cnt_reg[1:0] == 2'b11);
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                j_reg   <= ({1'b0, j_reg} == nk - 4'd1) ? 3'd0 : j_reg + 3'd1;
                if (!from_key && j_reg == 3'd0)
                    rcon_reg <= xtime(rcon_reg);
                if (is_last)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            for (int k = 0; k < 7; k++)
                win_reg[k] <= win_reg[k+1];
            win_reg[7] <= word;
            if (cnt_reg[1:0] == 2'b11)
            begin
                row_reg     <= {buf_reg[0], buf_reg[1], buf_reg[2], word};
                row_idx_reg <= cnt_reg[5:2];
            end
            else
                buf_reg[cnt_reg[1:0]] <= word;
        end
    end

    assign inner = (row_idx_reg != 4'd0) && (row_idx_reg != nr);

    always_comb
    begin
        wr.en       = row_vld_reg;
        wr.enc_row  = row_idx_reg;
        wr.dec_row  = nr - row_idx_reg;
        wr.enc_data = row_reg;
        for (int c = 0; c < 4; c++)
            wr.dec_data[127-32*c -: 32] = inner ? inv_mix_col(row_reg[127-32*c -: 32])
                                                : row_reg[127-32*c -: 32];
    end

    assign done = done_reg;

endmodule

`default_nettype wire

@@ design/aes_rk_store.sv @@
// ----------------------------------------------------------------------------
// aes round key store
// encryption and inverse cipher round keys, one 128-bit row per round
// ----------------------------------------------------------------------------
`default_nettype none

module aes_rk_store (
    input  wire                 clk,
    input  aes_pkg::aes_rk_wr_t wr,
    input  wire  [3:0]          rd_row,
    output logic [127:0]        enc_q,
    output logic [127:0]        dec_q
);
    import aes_pkg::*;

    logic [127:0] enc_mem [ROW_DEPTH];
    logic [127:0] dec_mem [ROW_DEPTH];
    logic [127:0] enc_q_reg;
    logic [127:0] dec_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            enc_mem[wr.enc_row] <= wr.enc_data;
            dec_mem[wr.dec_row] <= wr.dec_data;
        end
        enc_q_reg <= enc_mem[rd_row];
        dec_q_reg <= dec_mem[rd_row];
    end

    assign enc_q = enc_q_reg;
    assign dec_q = dec_q_reg;

endmodule

`default_nettype wire

@@ design/aes_round.sv @@
// ----------------------------------------------------------------------------
// aes round unit
// state register and one shared forward or inverse round per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round (
    input  wire                   clk,
    input  aes_pkg::aes_rnd_ctl_t ctl,
    input  wire  [127:0]          block,
    input  wire  [127:0]          enc_rk,
    input  wire  [127:0]          dec_rk,
    output logic [127:0]          state
);
    import aes_pkg::*;

    logic [127:0] state_reg;
    logic [127:0] state_next;
    logic [127:0] rk;
    logic [127:0] rnd;
    logic [31:0]  s [4];

    for (genvar j = 0; j < 4; j++) begin : g_s
        assign s[j] = state_reg[127-32*j -: 32];
    end

    for (genvar i = 0; i < 4; i++) begin : g_col
        localparam int I1 = (i + 1) % 4;
        localparam int I2 = (i + 2) % 4;
        localparam int I3 = (i + 3) % 4;
        logic [31:0] fwd;
        logic [31:0] inv;
        assign fwd = {SBOX[s[i][31:24]], SBOX[s[I1][23:16]],
                      SBOX[s[I2][15:8]], SBOX[s[I3][7:0]]};
        assign inv = {INV_SBOX[s[i][31:24]], INV_SBOX[s[I3][23:16]],
                      INV_SBOX[s[I2][15:8]], INV_SBOX[s[I1][7:0]]};
        always_comb
        begin
            if (ctl.last)
                rnd[127-32*i -: 32] = ctl.decrypt ? inv : fwd;
            else
                rnd[127-32*i -: 32] = ctl.decrypt ? inv_mix_col(inv) : mix_col(fwd);
        end
    end

    assign rk = ctl.decrypt ? dec_rk : enc_rk;

    always_comb
    begin
        if (ctl.load)
            state_next = block ^ rk;
        else if (ctl.step)
            state_next = rnd ^ rk;
        else
            state_next = state_reg;
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign state = state_reg;

endmodule

`default_nettype wire

@@ design/aes_block_cipher.sv @@
// ----------------------------------------------------------------------------
// aes block cipher
// aes-128/192/256 encrypt and decrypt with an on-chip round key schedule
//
//   port group   direction   handshake             payload
//   in           into block  in_valid / in_stall   aes_in_t
//   out          from block  out_valid / out_stall aes_out_t
//   cfg          into block  cfg_write             cfg_addr, cfg_data
//
// an item passes through key load, one round at a time in the shared round unit
//   (nr = 10, 12 or 14 rounds), then result and return to idle
// after a key or key size write the next item first expands the schedule,
//   4 * (nr + 1) words, one word per cycle
// reset clears the control and key registers and the key valid flag, the key store is not cleared
// a finished result waits in the round unit while out is stalled
// ----------------------------------------------------------------------------
`default_nettype none

module aes_block_cipher (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    input  aes_pkg::aes_in_t  in_data,
    output logic              out_valid,
    input  wire               out_stall,
    output aes_pkg::aes_out_t out_data,
    input  wire               cfg_write,
    input  wire  [2:0]        cfg_addr,
    input  wire  [63:0]       cfg_data
);
    import aes_pkg::*;

    aes_state_t   state_reg;
    aes_state_t   state_next;
    logic [1:0]   key_size_reg;
    logic [63:0]  key_reg [4];
    logic         keys_ready_reg;
    logic         func_reg;
    logic [127:0] block_reg;
    logic [3:0]   round_reg;
    logic [3:0]   round_next;
    logic         out_valid_reg;
    aes_out_t     out_data_reg;
    logic [3:0]   nr;
    logic         in_xfer;
    logic         kx_start;
    logic         kx_done;
    logic         load_out;
    logic [3:0]   rd_row;
    logic [127:0] enc_q;
    logic [127:0] dec_q;
    logic [127:0] cipher_state;
    aes_rk_wr_t   rk_wr;
    aes_rnd_ctl_t rnd_ctl;

    assign nr      = rounds_of(key_size_reg);
    assign in_xfer = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg   <= 2'd0;
            for (int k = 0; k < 4; k++)
                key_reg[k] <= 64'd0;
            keys_ready_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                CFG_KEY_SIZE:
                begin
                    key_size_reg   <= cfg_data[1:0];
                    keys_ready_reg <= 1'b0;
                end
                CFG_KEY_WORD_0:
                begin
                    key_reg[0]     <= cfg_data;
                    keys_ready_reg <= 1'b0;
                end
                CFG_KEY_WORD_1:
                begin
                    key_reg[1]     <= cfg_data;
                    keys_ready_reg <= 1'b0;
                end
                CFG_KEY_WORD_2:
                begin
                    key_reg[2]     <= cfg_data;
                    keys_ready_reg <= 1'b0;
                end
                CFG_KEY_WORD_3:
                begin
                    key_reg[3]     <= cfg_data;
                    keys_ready_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        else if (kx_done)
            keys_ready_reg <= 1'b1;
    end

    always_comb
    begin
        state_next  = state_reg;
        round_next  = round_reg;
        kx_start    = 1'b0;
        load_out    = 1'b0;
        rd_row      = 4'd0;
        rnd_ctl     = '0;
        rnd_ctl.decrypt = func_reg;
        in_stall    = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (keys_ready_reg)
                        state_next = ST_LOAD;
                    else
                    begin
                        kx_start   = 1'b1;
                        state_next = ST_EXPAND;
                    end
                end
            end
            ST_EXPAND:
            begin
                if (kx_done)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                rnd_ctl.load = 1'b1;
                rd_row       = 4'd1;
                round_next   = 4'd1;
                state_next   = ST_ROUND;
            end
            ST_ROUND:
            begin
                rnd_ctl.step = 1'b1;
                rnd_ctl.last = (round_reg == nr);
                rd_row       = round_reg + 4'd1;
                round_next   = round_reg + 4'd1;
                if (round_reg == nr)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg  <= in_data.func;
            block_reg <= {in_data.block_hi, in_data.block_lo};
        end
        if (load_out)
            out_data_reg <= aes_out_t'(cipher_state);
    end

    aes_key_exp u_key_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (kx_start),
        .key_size (key_size_reg),
        .key      ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .wr       (rk_wr),
        .done     (kx_done)
    );

    aes_rk_store u_rk_store (
        .clk    (clk),
        .wr     (rk_wr),
        .rd_row (rd_row),
        .enc_q  (enc_q),
        .dec_q  (dec_q)
    );

    aes_round u_round (
        .clk    (clk),
        .ctl    (rnd_ctl),
        .block  (block_reg),
        .enc_rk (enc_q),
        .dec_rk (dec_q),
        .state  (cipher_state)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ design/aes_checker.sv @@
// ----------------------------------------------------------------------------
// aes port checker
// transfer ordering and output hold checks on the top level ports
// ----------------------------------------------------------------------------
`default_nettype none

`include "aes_block_cipher_defines.svh"

module aes_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               in_valid,
    input wire               in_stall,
    input wire               out_valid,
    input wire               out_stall,
    input aes_pkg::aes_out_t out_data
);

    `AES_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

    `AES_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "second item taken while busy")

    `AES_ASSERT_ALWAYS(a_out_known, !out_valid || !$isunknown(out_data), "result has unknown bits")

endmodule

bind aes_block_cipher aes_checker u_aes_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// aes block cipher testbench
// drives encrypt and decrypt transfers under several key sizes and keys,
// predicts every result with an independent aes model and compares them in
// order; both sides idle in random bursts, with a quiet stretch at the end
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import aes_pkg::*;

    localparam logic FUNC_ENC = 1'b0;
    localparam logic FUNC_DEC = 1'b1;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1300;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    aes_in_t in_data;
    logic out_valid;
    logic out_stall;
    aes_out_t out_data;
    logic cfg_write;
    logic [2:0] cfg_addr;
    logic [63:0] cfg_data;

    aes_block_cipher i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // key registers and schedule copy
    logic [1:0] mdl_key_size;
    logic [63:0] mdl_key [4];
    logic [31:0] enc_keys [60];
    logic [31:0] dec_keys [60];
    logic schedule_valid;

    aes_out_t pending_blocks [$];
    int errors;
    int idle_cycles;
    bit quiet;
    bit stall_enable;

    typedef struct {
        logic func;
        logic [63:0] hi;
        logic [63:0] lo;
        bit known;
        logic [63:0] want_hi;
        logic [63:0] want_lo;
    } vector_t;

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] ginv(input logic [7:0] x);
        logic [7:0] r;
        r = 8'h01;
        for (int i = 0; i < 254; i++)
            r = gmul(r, x);
        return r;
    endfunction

    logic [7:0] fwd_box [256];
    logic [7:0] rev_box [256];

    function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    task automatic build_boxes();
        logic [7:0] b;
        for (int x = 0; x < 256; x++)
        begin
            b = ginv(x[7:0]);
            b = b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
            fwd_box[x] = b;
            rev_box[b] = x[7:0];
        end
    endtask

    function automatic logic [31:0] col_mix(input logic [31:0] w, input bit inverse);
        logic [7:0] a [4];
        logic [7:0] c [4];
        logic [31:0] r;
        for (int k = 0; k < 4; k++)
        begin
            a[k] = w[31 - 8 * k -: 8];
            c[k] = inverse ? (k == 0 ? 8'd14 : k == 1 ? 8'd11 : k == 2 ? 8'd13 : 8'd9)
                           : (k == 0 ? 8'd2 : k == 1 ? 8'd3 : 8'd1);
        end
        for (int row = 0; row < 4; row++)
            r[31 - 8 * row -: 8] = gmul(a[0], c[(4 - row) % 4]) ^ gmul(a[1], c[(5 - row) % 4])
                                 ^ gmul(a[2], c[(6 - row) % 4]) ^ gmul(a[3], c[(7 - row) % 4]);
        return r;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
    endfunction

    function automatic int num_rounds();
        return mdl_key_size == 2'd0 ? 10 : mdl_key_size == 2'd1 ? 12 : 14;
    endfunction

    task automatic expand_schedule();
        int nr;
        int nk;
        logic [31:0] w [60];
        logic [31:0] t;
        logic [7:0] rc;
        nr = num_rounds();
        nk = nr - 6;
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            w[i] = i[0] ? mdl_key[i / 2][31:0] : mdl_key[i / 2][63:32];
        for (int i = nk; i < 4 * (nr + 1); i++)
        begin
            t = w[i - 1];
            if (i % nk == 0)
            begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gmul(rc, 8'h02);
            end
            else if (nk == 8 && i % nk == 4)
                t = sbox_word(t);
            w[i] = w[i - nk] ^ t;
        end
        for (int r = 0; r <= nr; r++)
            for (int c = 0; c < 4; c++)
            begin
                enc_keys[4 * r + c] = w[4 * r + c];
                dec_keys[4 * (nr - r) + c] = (r == 0 || r == nr) ? w[4 * r + c]
                                           : col_mix(w[4 * r + c], 1'b1);
            end
        schedule_valid = 1'b1;
    endtask

    function automatic aes_out_t cipher_block(input aes_in_t item);
        logic [31:0] s [4];
        logic [31:0] a [4];
        logic [31:0] col;
        logic [31:0] k;
        bit dec;
        int nr;
        nr = num_rounds();
        dec = item.func;
        s[0] = item.block_hi[63:32];
        s[1] = item.block_hi[31:0];
        s[2] = item.block_lo[63:32];
        s[3] = item.block_lo[31:0];
        for (int i = 0; i < 4; i++)
            s[i] ^= dec ? dec_keys[i] : enc_keys[i];
        for (int r = 1; r <= nr; r++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (!dec)
                    col = {fwd_box[s[i][31:24]], fwd_box[s[(i + 1) % 4][23:16]],
                           fwd_box[s[(i + 2) % 4][15:8]], fwd_box[s[(i + 3) % 4][7:0]]};
                else
                    col = {rev_box[s[i][31:24]], rev_box[s[(i + 3) % 4][23:16]],
                           rev_box[s[(i + 2) % 4][15:8]], rev_box[s[(i + 1) % 4][7:0]]};
                if (r < nr)
                    col = col_mix(col, dec);
                k = dec ? dec_keys[4 * r + i] : enc_keys[4 * r + i];
                a[i] = col ^ k;
            end
            s = a;
        end
        return '{result_hi: {s[0], s[1]}, result_lo: {s[2], s[3]}};
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stall bursts and in-order compare
    initial
    begin
        int burst;
        aes_out_t want;
        out_stall = 1'b0;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                idle_cycles = 0;
                if (pending_blocks.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    errors++;
                end
                else
                begin
                    want = pending_blocks.pop_front();
                    if (out_data.result_hi !== want.result_hi)
                    begin
                        $display("%0t: result_hi expected %h actual %h", $time,
                                 want.result_hi, out_data.result_hi);
                        errors++;
                    end
                    if (out_data.result_lo !== want.result_lo)
                    begin
                        $display("%0t: result_lo expected %h actual %h", $time,
                                 want.result_lo, out_data.result_lo);
                        errors++;
                    end
                end
            end
            if (burst > 0)
                burst--;
            else if (stall_enable && !quiet && $urandom_range(0, 9) == 0)
                burst = $urandom_range(1, 19);
            out_stall <= (burst > 0);
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        forever
        begin
            @(posedge clk);
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] addr, input logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (addr == CFG_KEY_SIZE)
            mdl_key_size = value[1:0];
        else if (addr <= CFG_KEY_WORD_3)
            mdl_key[addr - 1] = value;
        else
            return;
        schedule_valid = 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_block(input aes_in_t item, input bit may_gap);
        if (may_gap && !quiet && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        idle_cycles = 0;
        if (!schedule_valid)
            expand_schedule();
        pending_blocks.push_back(cipher_block(item));
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic load_key(input logic [1:0] ks, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        write_reg(CFG_KEY_SIZE, {62'h0, ks});
        write_reg(CFG_KEY_WORD_0, k0);
        write_reg(CFG_KEY_WORD_1, k1);
        write_reg(CFG_KEY_WORD_2, k2);
        write_reg(CFG_KEY_WORD_3, k3);
    endtask

    initial
    begin
        vector_t vectors [$];
        aes_in_t item;
        int n;
        errors = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        stall_enable = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_addr = CFG_KEY_SIZE;
        cfg_data = '0;
        mdl_key_size = 2'd0;
        for (int i = 0; i < 4; i++)
            mdl_key[i] = '0;
        schedule_valid = 1'b0;
        build_boxes();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // known-answer checks with the zero key after reset, then all-ones blocks checked against the model
        vectors.push_back('{FUNC_ENC, 64'h0, 64'h0, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e});
        vectors.push_back('{FUNC_DEC, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1, 64'h0, 64'h0});
        vectors.push_back('{FUNC_ENC, '1, '1, 0, 0, 0});
        vectors.push_back('{FUNC_DEC, '1, '1, 0, 0, 0});
        foreach (vectors[i])
        begin
            item = '{func: vectors[i].func, block_hi: vectors[i].hi, block_lo: vectors[i].lo};
            send_block(item, 1'b0);
            if (vectors[i].known &&
                pending_blocks[$] !== aes_out_t'{vectors[i].want_hi, vectors[i].want_lo})
            begin
                $display("%0t: predictor expected %h %h actual %h", $time, vectors[i].want_hi,
                         vectors[i].want_lo, pending_blocks[$]);
                errors++;
            end
        end
        drain();

        // fips-197 example keys for each size, and the unused size code
        for (int ks = 0; ks < 4; ks++)
        begin
            load_key(ks[1:0], 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                     64'h1011121314151617, 64'h18191a1b1c1d1e1f);
            write_reg(3'd7, rand64());
            item = '{func: 1'b0, block_hi: 64'h0011223344556677, block_lo: 64'h8899aabbccddeeff};
            send_block(item, 1'b0);
            item.func = 1'b1;
            send_block(item, 1'b0);
            drain();
        end
        stall_enable = 1'b1;
        load_key(2'd2, '1, '1, '1, '1);
        send_block('{1'b0, '1, '1}, 1'b0);
        send_block('{1'b1, 64'h0, 64'h0}, 1'b0);
        drain();

        // random phases: each a fresh key setting with a run of blocks
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            load_key(2'($urandom_range(0, 3)), rand64(), rand64(), rand64(), rand64());
            if ($urandom_range(0, 3) == 0)
                write_reg(3'($urandom_range(0, 4)), rand64());
            for (int j = $urandom_range(10, 80); j > 0 && n < RANDOM_ITEMS; j--)
            begin
                if (n > RANDOM_ITEMS - 100)
                begin
                    quiet = 1'b1;
                    stall_enable = 1'b0;
                end
                item = '{func: 1'($urandom_range(0, 1)), block_hi: rand64(), block_lo: rand64()};
                send_block(item, 1'b1);
                n++;
            end
            drain();
        end

        in_valid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
